// ===== hdl/ktau_pkg.sv =====
package ktau_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_SAMPLES_DEF = 256;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed widths of the word fields.
  localparam int FIELD_W   = 16;
  localparam int CNT_OUT_W = 15;
  localparam int TAU_W     = 16;
  localparam int SEEN_W    = 9;

  // The quotient is built one bit per division step.
  localparam int STEP_W = $clog2(TAU_W);

  localparam logic [TAU_W-1:0] TAU_POS_MAX = {1'b0, {(TAU_W-1){1'b1}}};
  localparam logic [TAU_W-1:0] TAU_NEG_MAG = {1'b1, {(TAU_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_sample;
    logic signed [FIELD_W-1:0] y_sample;
    logic                      final_sample;
  } ktau_in_t;

  typedef struct packed {
    logic        [CNT_OUT_W-1:0] concordant_pairs;
    logic        [CNT_OUT_W-1:0] discordant_pairs;
    logic signed [TAU_W-1:0]     tau_value;
    logic        [SEEN_W-1:0]    samples_seen;
    logic                        degenerate;
    logic                        overflowed;
  } ktau_out_t;

  // Control bits that travel with a sample along the cell chain.
  typedef struct packed {
    logic vld;     // a sample occupies this stage
    logic act;     // the sample belongs to the data set (not dropped)
    logic fin;     // last sample of the data set
    logic placed;  // the sample has already been written into a cell
  } ktau_ctl_t;

  typedef enum logic [1:0] {
    KT_IDLE,
    KT_PAIRS,
    KT_DIVIDE,
    KT_HOLD
  } ktau_state_t;

endpackage

// ===== hdl/ktau_cell.sv =====
module ktau_cell import ktau_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES_DEF)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  ktau_ctl_t                     ctl_in,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  input  logic signed [SAMPLE_BITS-1:0] y_in,
  input  logic        [CNT_W-1:0]       conc_in,
  input  logic        [CNT_W-1:0]       disc_in,
  output ktau_ctl_t                     ctl_out,
  output logic signed [SAMPLE_BITS-1:0] x_out,
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output logic        [CNT_W-1:0]       conc_out,
  output logic        [CNT_W-1:0]       disc_out
);

  logic signed [SAMPLE_BITS-1:0] stored_x;
  logic signed [SAMPLE_BITS-1:0] stored_y;
  logic                          slot_valid;
  logic                          slot_valid_next;

  logic hit;
  logic capture;
  logic gt_x, lt_x, gt_y, lt_y;
  logic conc, disc;

  // The passing sample is compared with the stored one, and the first empty
  // cell it meets takes it, unless it is the last sample of its set.
  assign hit     = ctl_in.vld & ctl_in.act & slot_valid;
  assign capture = ctl_in.vld & ctl_in.act & ~ctl_in.placed & ~slot_valid;

  assign gt_x = stored_x > x_in;
  assign lt_x = stored_x < x_in;
  assign gt_y = stored_y > y_in;
  assign lt_y = stored_y < y_in;

  assign conc = hit & ((gt_x & gt_y) | (lt_x & lt_y));
  assign disc = hit & ((gt_x & lt_y) | (lt_x & gt_y));

  // The last sample of a set empties every cell it passes.
  always_comb begin
    slot_valid_next = slot_valid;
    if (ctl_in.vld && ctl_in.fin) begin
      slot_valid_next = 1'b0;
    end else if (capture) begin
      slot_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= 1'b0;
      ctl_out     <= '0;
    end else if (advance) begin
      slot_valid     <= slot_valid_next;
      ctl_out.vld    <= ctl_in.vld;
      ctl_out.act    <= ctl_in.act;
      ctl_out.fin    <= ctl_in.fin;
      ctl_out.placed <= ctl_in.placed | capture;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (capture) begin
        stored_x <= x_in;
        stored_y <= y_in;
      end
      x_out    <= x_in;
      y_out    <= y_in;
      conc_out <= conc_in + CNT_W'(conc);
      disc_out <= disc_in + CNT_W'(disc);
    end
  end

endmodule

// ===== hdl/ktau_tau_unit.sv =====
module ktau_tau_unit import ktau_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               advance,
  input  ktau_ctl_t                          tail_ctl,
  input  logic [$clog2(MAX_SAMPLES)-1:0]     tail_conc,
  input  logic [$clog2(MAX_SAMPLES)-1:0]     tail_disc,
  output logic                               ready,
  output logic                               result_valid,
  input  logic                               result_stall,
  output ktau_out_t                          result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES);
  localparam int TOT_W = $clog2(MAX_SAMPLES * (MAX_SAMPLES - 1) / 2 + 1);
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int P_W   = 2 * N_W;

  ktau_state_t state, state_next;

  // Running totals of the data set still arriving at the chain's tail.
  logic [TOT_W-1:0] conc_tot, disc_tot;
  logic [N_W-1:0]   n_tot;
  logic             ovf_tot;

  logic [TOT_W-1:0] conc_sum, disc_sum;
  logic [N_W-1:0]   n_sum;
  logic             ovf_sum;
  logic             consume, launch;

  // Latched result of a finished set.
  logic [TOT_W-1:0] conc_res, disc_res;
  logic [N_W-1:0]   n_res;
  logic             ovf_res;
  logic             degen;

  logic [P_W-1:0]    prod;
  logic [TOT_W-1:0]  pairs;
  logic              neg;
  logic [TOT_W:0]    rem;
  logic [TAU_W-1:0]  quot;
  logic [STEP_W-1:0] step;
  logic              ge;
  logic              last_step;
  logic [TAU_W-1:0]  tau_mag;

  logic load_res, load_pairs, div_en;

  assign consume = advance & tail_ctl.vld;
  assign launch  = consume & tail_ctl.fin;

  assign conc_sum = conc_tot + TOT_W'(tail_conc);
  assign disc_sum = disc_tot + TOT_W'(tail_disc);
  assign n_sum    = n_tot + N_W'(tail_ctl.act);
  assign ovf_sum  = ovf_tot | ~tail_ctl.act;

  assign prod      = P_W'(n_res) * P_W'(n_res - 1'b1);
  assign ge        = rem >= {1'b0, pairs};
  assign last_step = step == STEP_W'(TAU_W - 1);

  always_comb begin
    state_next = state;
    case (state)
      KT_IDLE:   if (launch) state_next = KT_PAIRS;
      KT_PAIRS:  state_next = KT_DIVIDE;
      KT_DIVIDE: if (last_step) state_next = KT_HOLD;
      KT_HOLD:   if (!result_stall) state_next = KT_IDLE;
      default:   state_next = KT_IDLE;
    endcase
  end

  always_comb begin
    ready        = 1'b0;
    load_res     = 1'b0;
    load_pairs   = 1'b0;
    div_en       = 1'b0;
    result_valid = 1'b0;
    case (state)
      KT_IDLE: begin
        ready    = 1'b1;
        load_res = launch;
      end
      KT_PAIRS:  load_pairs   = 1'b1;
      KT_DIVIDE: div_en       = 1'b1;
      KT_HOLD:   result_valid = 1'b1;
      default:   ready        = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= KT_IDLE;
      conc_tot <= '0;
      disc_tot <= '0;
      n_tot    <= '0;
      ovf_tot  <= 1'b0;
    end else begin
      state <= state_next;
      if (consume) begin
        if (tail_ctl.fin) begin
          conc_tot <= '0;
          disc_tot <= '0;
          n_tot    <= '0;
          ovf_tot  <= 1'b0;
        end else begin
          conc_tot <= conc_sum;
          disc_tot <= disc_sum;
          n_tot    <= n_sum;
          ovf_tot  <= ovf_sum;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle: the first bit is the
  // integer part of |C - D| / pairs, the rest are the fraction.
  always_ff @(posedge clk) begin
    if (load_res) begin
      conc_res <= conc_sum;
      disc_res <= disc_sum;
      n_res    <= n_sum;
      ovf_res  <= ovf_sum;
      degen    <= n_sum < N_W'(2);
    end
    if (load_pairs) begin
      pairs <= TOT_W'(prod >> 1);
      neg   <= disc_res > conc_res;
      rem   <= (disc_res > conc_res) ? {1'b0, disc_res - conc_res}
                                     : {1'b0, conc_res - disc_res};
      quot  <= '0;
      step  <= '0;
    end
    if (div_en) begin
      rem  <= (ge ? rem - {1'b0, pairs} : rem) << 1;
      quot <= {quot[TAU_W-2:0], ge};
      step <= step + 1'b1;
    end
  end

  always_comb begin
    if (neg) begin
      tau_mag = (quot > TAU_NEG_MAG) ? TAU_NEG_MAG : quot;
    end else begin
      tau_mag = (quot > TAU_POS_MAX) ? TAU_POS_MAX : quot;
    end
  end

  always_comb begin
    result.concordant_pairs = CNT_OUT_W'(conc_res);
    result.discordant_pairs = CNT_OUT_W'(disc_res);
    result.samples_seen     = SEEN_W'(n_res);
    result.degenerate       = degen;
    result.overflowed       = ovf_res;
    if (degen) begin
      result.tau_value = '0;
    end else if (neg) begin
      result.tau_value = -$signed(tau_mag);
    end else begin
      result.tau_value = $signed(tau_mag);
    end
  end

endmodule

// ===== hdl/kendall_tau_rank_correlation.sv =====
// Kendall tau-a over a stream of (x, y) sample words. Each accepted word
// enters a chain of MAX_SAMPLES cells and moves one cell per cycle; every
// cell holds one stored pair of the current data set, compares it with the
// passing word and adds the concordant or discordant outcome to counts that
// travel with the word. The first empty cell keeps the word, and the word
// marked final empties every cell it passes, so the next data set may follow
// right behind it. The chain takes one word per clock. It holds, and stall
// rises, only when a final word reaches the end of the chain while the tau
// unit is still busy with, or still holding, the previous result. A result
// word follows its final word through the MAX_SAMPLES chain cells, then a
// state that forms n(n-1)/2, then the one-bit-per-cycle division for tau
// in Q1.15. Words that arrive while a set already holds MAX_SAMPLES
// samples are dropped and reported through the overflowed flag. Sets of
// fewer than two samples report degenerate with tau zero.
module kendall_tau_rank_correlation import ktau_pkg::*; #(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_stall,
  input  ktau_in_t  sample,
  output logic      result_valid,
  input  logic      result_stall,
  output ktau_out_t result
);

  localparam int CNT_W = $clog2(MAX_SAMPLES);
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);

  // Chain nodes: node 0 is the entry, node MAX_SAMPLES the tail.
  ktau_ctl_t                     ctl  [MAX_SAMPLES+1];
  logic signed [SAMPLE_BITS-1:0] xs   [MAX_SAMPLES+1];
  logic signed [SAMPLE_BITS-1:0] ys   [MAX_SAMPLES+1];
  logic        [CNT_W-1:0]       conc [MAX_SAMPLES+1];
  logic        [CNT_W-1:0]       disc [MAX_SAMPLES+1];

  logic           advance;
  logic           unit_ready;
  logic           accept;
  logic           in_set;
  logic [N_W-1:0] entry_count;

  // The whole chain moves together; it waits only when a final word at the
  // tail cannot hand its totals to the tau unit.
  assign advance      = ~(ctl[MAX_SAMPLES].vld & ctl[MAX_SAMPLES].fin) | unit_ready;
  assign sample_stall = ~advance;
  assign accept       = sample_valid & advance;

  // Words beyond capacity still travel, so that their final mark and the
  // overflow are seen at the tail, but they take no part in comparisons.
  assign in_set = entry_count != N_W'(MAX_SAMPLES);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept) begin
      if (sample.final_sample) begin
        entry_count <= '0;
      end else if (in_set) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  always_comb begin
    ctl[0].vld    = accept;
    ctl[0].act    = in_set;
    ctl[0].fin    = sample.final_sample;
    ctl[0].placed = 1'b0;
  end

  // Samples narrower than the field keep their low bits and sign; wider ones
  // take the field as an unsigned value.
  assign xs[0]   = SAMPLE_BITS'($unsigned(sample.x_sample));
  assign ys[0]   = SAMPLE_BITS'($unsigned(sample.y_sample));
  assign conc[0] = '0;
  assign disc[0] = '0;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    ktau_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .ctl_in   (ctl[i]),
      .x_in     (xs[i]),
      .y_in     (ys[i]),
      .conc_in  (conc[i]),
      .disc_in  (disc[i]),
      .ctl_out  (ctl[i+1]),
      .x_out    (xs[i+1]),
      .y_out    (ys[i+1]),
      .conc_out (conc[i+1]),
      .disc_out (disc[i+1])
    );
  end

  // The tail's sample values have done their work; only counts and control
  // go on to the tau unit.
  ktau_tau_unit #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_tau (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .tail_ctl     (ctl[MAX_SAMPLES]),
    .tail_conc    (conc[MAX_SAMPLES]),
    .tail_disc    (disc[MAX_SAMPLES]),
    .ready        (unit_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
